// ----- hdl/joystick_override_command_mux_defines.svh -----
// Assertion macros shared by the joystick override mux RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef JOYSTICK_OVERRIDE_COMMAND_MUX_DEFINES_SVH
`define JOYSTICK_OVERRIDE_COMMAND_MUX_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define JOCM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("joystick override mux check failed");
`define JOCM_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("joystick override mux check failed");
`else
`define JOCM_ASSERT(lbl, clk, rst, prop)
`define JOCM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- hdl/jocm_pkg.sv -----
// Shared types, constants and helper functions for the joystick override mux.
// No dependencies; used by all jocm modules and the top level.
`timescale 1ns / 1ps
`default_nettype none

package jocm_pkg;

   localparam int NUM_AXES    = 8;
   localparam int NUM_BUTTONS = 16;
   localparam int AXIS_W      = 16;
   localparam int AXES_W      = 128;
   localparam int PROD_W      = 33;
   localparam int ACC_W       = 50;
   localparam int ROUND_SHIFT = 26;
   localparam int BOOST_SHIFT = 12;

   localparam logic [2:0] REG_LINEAR_GAIN   = 3'd0;
   localparam logic [2:0] REG_ANGULAR_GAIN  = 3'd1;
   localparam logic [2:0] REG_LINEAR_BOOST  = 3'd2;
   localparam logic [2:0] REG_ANGULAR_BOOST = 3'd3;
   localparam logic [2:0] REG_TIMEOUT       = 3'd4;
   localparam logic [2:0] REG_AXIS_MAP      = 3'd5;
   localparam logic [2:0] REG_BUTTON_MAP    = 3'd6;

   localparam logic [15:0] RST_LINEAR_GAIN   = 16'd2048;
   localparam logic [15:0] RST_ANGULAR_GAIN  = 16'd3277;
   localparam logic [15:0] RST_LINEAR_BOOST  = 16'd5325;
   localparam logic [15:0] RST_ANGULAR_BOOST = 16'd4506;
   localparam logic [31:0] RST_TIMEOUT       = 32'd500;
   localparam logic [15:0] RST_AXIS_MAP      = 16'd1;
   localparam logic [8:0]  RST_BUTTON_MAP    = 9'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_BOOST,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic [15:0] linear_gain;
      logic [15:0] angular_gain;
      logic [15:0] linear_boost;
      logic [15:0] angular_boost;
      logic [31:0] timeout_ticks;
      logic [15:0] axis_map;
      logic [8:0]  button_map;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic scale;
      logic boosted;
   } lane_ctrl_type;

   typedef struct packed {
      logic signed [15:0] lin_x;
      logic signed [15:0] lin_y;
      logic signed [15:0] lin_z;
      logic signed [15:0] ang_x;
      logic signed [15:0] ang_y;
      logic signed [15:0] ang_z;
   } twist_type;

   typedef struct packed {
      logic      has_twist;
      logic      has_status;
      logic      pass_status;
      twist_type twist;
   } result_type;

   // out-of-range index reads as zero
   function automatic logic signed [AXIS_W-1:0] axis_value(
      input logic [AXES_W-1:0] axes, input logic [3:0] idx);
      logic signed [AXIS_W-1:0] v;
      v = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         if (idx == 4'(i)) begin
            v = axes[i*AXIS_W +: AXIS_W];
         end
      end
      return v;
   endfunction

   function automatic logic button_on(input logic [15:0] btn, input logic [3:0] idx);
      logic on;
      on = 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (idx == 4'(i)) begin
            on = btn[i];
         end
      end
      return on;
   endfunction

   function automatic logic [AXIS_W:0] magnitude(input logic signed [AXIS_W-1:0] v);
      return v[AXIS_W-1] ? (~{v[AXIS_W-1], v} + 17'd1) : {1'b0, v};
   endfunction

endpackage

`default_nettype wire

// ----- hdl/jocm_csr.sv -----
// APB-style register file for gains, boost ratios, timeout and input maps.
// Depends on jocm_pkg for register indexes, reset values and cfg_type.
`timescale 1ns / 1ps
`default_nettype none

module jocm_csr (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [4:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready,
   output jocm_pkg::cfg_type       cfg
);

   jocm_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [2:0]        reg_idx;

   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[4:2];
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            jocm_pkg::REG_LINEAR_GAIN:   cfg_in.linear_gain   = pwdata[15:0];
            jocm_pkg::REG_ANGULAR_GAIN:  cfg_in.angular_gain  = pwdata[15:0];
            jocm_pkg::REG_LINEAR_BOOST:  cfg_in.linear_boost  = pwdata[15:0];
            jocm_pkg::REG_ANGULAR_BOOST: cfg_in.angular_boost = pwdata[15:0];
            jocm_pkg::REG_TIMEOUT:       cfg_in.timeout_ticks = pwdata;
            jocm_pkg::REG_AXIS_MAP:      cfg_in.axis_map      = pwdata[15:0];
            jocm_pkg::REG_BUTTON_MAP:    cfg_in.button_map    = pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         jocm_pkg::REG_LINEAR_GAIN:   prdata = {16'd0, cfg_ff.linear_gain};
         jocm_pkg::REG_ANGULAR_GAIN:  prdata = {16'd0, cfg_ff.angular_gain};
         jocm_pkg::REG_LINEAR_BOOST:  prdata = {16'd0, cfg_ff.linear_boost};
         jocm_pkg::REG_ANGULAR_BOOST: prdata = {16'd0, cfg_ff.angular_boost};
         jocm_pkg::REG_TIMEOUT:       prdata = cfg_ff.timeout_ticks;
         jocm_pkg::REG_AXIS_MAP:      prdata = {16'd0, cfg_ff.axis_map};
         jocm_pkg::REG_BUTTON_MAP:    prdata = {23'd0, cfg_ff.button_map};
         default:                     prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.linear_gain   <= jocm_pkg::RST_LINEAR_GAIN;
         cfg_ff.angular_gain  <= jocm_pkg::RST_ANGULAR_GAIN;
         cfg_ff.linear_boost  <= jocm_pkg::RST_LINEAR_BOOST;
         cfg_ff.angular_boost <= jocm_pkg::RST_ANGULAR_BOOST;
         cfg_ff.timeout_ticks <= jocm_pkg::RST_TIMEOUT;
         cfg_ff.axis_map      <= jocm_pkg::RST_AXIS_MAP;
         cfg_ff.button_map    <= jocm_pkg::RST_BUTTON_MAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/jocm_lane.sv -----
// One velocity lane: axis pick with secondary override, gain and boost
// multiply, then round to Q3.12 and saturate. Depends on jocm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jocm_lane (
   input  wire logic                               clock,
   input  wire jocm_pkg::lane_ctrl_type            ctrl,
   input  wire logic [jocm_pkg::AXES_W-1:0]        axes,
   input  wire logic [3:0]                         prim_idx,
   input  wire logic [3:0]                         sec_sel,
   input  wire logic [15:0]                        gain,
   input  wire logic [15:0]                        ratio,
   output logic signed [15:0]                      result
);

   logic signed [jocm_pkg::AXIS_W-1:0] sel_ff, sel_in;
   logic signed [jocm_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [jocm_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [jocm_pkg::AXIS_W-1:0] prim_v, sec_v;
   logic signed [jocm_pkg::ACC_W-1:0]  biased;
   logic signed [jocm_pkg::ACC_W-jocm_pkg::ROUND_SHIFT-1:0] rounded;

   assign prim_v = jocm_pkg::axis_value(axes, prim_idx);
   assign sec_v  = jocm_pkg::axis_value(axes, {1'b0, sec_sel[2:0]});

   always_comb begin
      sel_in = sel_ff;
      if (ctrl.load) begin
         if (sec_sel[3] && (jocm_pkg::magnitude(sec_v) > jocm_pkg::magnitude(prim_v))) begin
            sel_in = sec_v;
         end else begin
            sel_in = prim_v;
         end
      end
   end

   always_comb begin
      prod_in = prod_ff;
      if (ctrl.mul) begin
         prod_in = sel_ff * $signed({1'b0, gain});
      end
   end

   // unboosted products are lifted by the boost fraction so one rounding fits both
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.scale) begin
         if (ctrl.boosted) begin
            acc_in = prod_ff * $signed({1'b0, ratio});
         end else begin
            acc_in = {{(jocm_pkg::ACC_W-jocm_pkg::PROD_W){prod_ff[jocm_pkg::PROD_W-1]}}, prod_ff}
                     <<< jocm_pkg::BOOST_SHIFT;
         end
      end
   end

   assign biased  = acc_ff + (50'sd1 <<< (jocm_pkg::ROUND_SHIFT - 1));
   assign rounded = biased[jocm_pkg::ACC_W-1:jocm_pkg::ROUND_SHIFT];

   always_comb begin
      if (rounded > 24'sd32767) begin
         result = 16'sh7FFF;
      end else if (rounded < -24'sd32768) begin
         result = 16'sh8000;
      end else begin
         result = rounded[15:0];
      end
   end

   always_ff @(posedge clock) begin
      sel_ff  <= sel_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule

`default_nettype wire

// ----- hdl/jocm_merge.sv -----
// Merge stage and output register: joins the two lane results or the
// autonomous pass/block outcome into one result word. Depends on jocm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jocm_merge (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire logic                  is_joy,
   input  wire logic                  pass,
   input  wire logic signed [15:0]    lin,
   input  wire logic signed [15:0]    ang,
   input  wire jocm_pkg::twist_type   auto_twist,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output jocm_pkg::result_type       rsp
);

   logic                 valid_ff, valid_in;
   jocm_pkg::result_type out_ff, out_in;

   always_comb begin
      out_in   = out_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
         out_in   = '0;
         if (is_joy) begin
            out_in.has_twist   = 1'b1;
            out_in.twist.lin_x = lin;
            out_in.twist.ang_z = ang;
         end else begin
            out_in.has_status  = 1'b1;
            if (pass) begin
               out_in.has_twist   = 1'b1;
               out_in.pass_status = 1'b1;
               out_in.twist       = auto_twist;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = out_ff;

endmodule

`default_nettype wire

// ----- hdl/joystick_override_command_mux.sv -----
// Joystick override command mux: the request channel takes joystick or
// autonomous twist words, the response channel gives at most one word each.
// A joystick word with the deadman button held goes through accept, gain
// multiply, boost multiply, then merge into the output register; its
// response is valid once the merge has loaded that register, and no new
// request is taken until the merge is done. The linear and angular lanes
// run side by side, each with its own 16x17 and 33x17 multiply, one per cycle.
// An autonomous word goes through accept and merge; a joystick word with the
// deadman released is done at acceptance and gives no response.
// The output register lets a new request be accepted while a response waits;
// if the receiver stalls, a finished word holds in the merge step and
// req_stall stays high until the output register frees.
// Reset (synchronous, active high) restores register defaults, clears the
// override and drops any word in flight. Config is written over the APB port.
// Depends on jocm_pkg, jocm_csr, jocm_lane, jocm_merge and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "joystick_override_command_mux_defines.svh"

module joystick_override_command_mux (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [4:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_mode,
   input  wire logic [31:0]        req_time_now,
   input  wire logic [63:0]        req_axes_low,
   input  wire logic [63:0]        req_axes_high,
   input  wire logic [15:0]        req_buttons,
   input  wire logic signed [15:0] req_in_linear_x,
   input  wire logic signed [15:0] req_in_linear_y,
   input  wire logic signed [15:0] req_in_linear_z,
   input  wire logic signed [15:0] req_in_angular_x,
   input  wire logic signed [15:0] req_in_angular_y,
   input  wire logic signed [15:0] req_in_angular_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_has_twist,
   output logic                    rsp_has_status,
   output logic                    rsp_pass_status,
   output logic signed [15:0]      rsp_out_linear_x,
   output logic signed [15:0]      rsp_out_linear_y,
   output logic signed [15:0]      rsp_out_linear_z,
   output logic signed [15:0]      rsp_out_angular_x,
   output logic signed [15:0]      rsp_out_angular_y,
   output logic signed [15:0]      rsp_out_angular_z
);

   jocm_pkg::cfg_type       cfg;
   jocm_pkg::state_type     state_ff, state_in;
   jocm_pkg::lane_ctrl_type lane_ctrl;
   jocm_pkg::twist_type     auto_ff, auto_in;
   jocm_pkg::result_type    rsp;

   logic        override_ff, override_in;
   logic [31:0] last_time_ff, last_time_in;
   logic        pass_ff, pass_in;
   logic        is_joy_ff, is_joy_in;
   logic        boosted_ff, boosted_in;
   logic        req_accept, deadman, boost_btn, push;
   logic [31:0] age;
   logic signed [15:0] lin_res, ang_res;
   logic [jocm_pkg::AXES_W-1:0] axes;

   jocm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_stall  = (state_ff != jocm_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign axes       = {req_axes_high, req_axes_low};
   assign deadman    = jocm_pkg::button_on(req_buttons, cfg.button_map[3:0]);
   assign boost_btn  = cfg.button_map[8] && jocm_pkg::button_on(req_buttons, cfg.button_map[7:4]);
   assign age        = req_time_now - last_time_ff;
   assign push       = (state_ff == jocm_pkg::ST_PUSH) && (!rsp_valid || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      override_in  = override_ff;
      last_time_in = last_time_ff;
      pass_in      = pass_ff;
      is_joy_in    = is_joy_ff;
      boosted_in   = boosted_ff;
      auto_in      = auto_ff;
      case (state_ff)
         jocm_pkg::ST_IDLE: begin
            if (req_accept) begin
               is_joy_in  = !req_mode;
               boosted_in = boost_btn;
               if (req_mode) begin
                  pass_in       = !override_ff || (age > cfg.timeout_ticks);
                  auto_in.lin_x = req_in_linear_x;
                  auto_in.lin_y = req_in_linear_y;
                  auto_in.lin_z = req_in_linear_z;
                  auto_in.ang_x = req_in_angular_x;
                  auto_in.ang_y = req_in_angular_y;
                  auto_in.ang_z = req_in_angular_z;
                  state_in      = jocm_pkg::ST_PUSH;
               end else if (deadman) begin
                  override_in  = 1'b1;
                  last_time_in = req_time_now;
                  state_in     = jocm_pkg::ST_MUL;
               end else begin
                  override_in = 1'b0;
               end
            end
         end
         jocm_pkg::ST_MUL:   state_in = jocm_pkg::ST_BOOST;
         jocm_pkg::ST_BOOST: state_in = jocm_pkg::ST_PUSH;
         jocm_pkg::ST_PUSH: begin
            if (push) begin
               state_in = jocm_pkg::ST_IDLE;
            end
         end
         default: state_in = jocm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jocm_pkg::ST_IDLE;
         override_ff  <= 1'b0;
         last_time_ff <= 32'd0;
      end else begin
         state_ff     <= state_in;
         override_ff  <= override_in;
         last_time_ff <= last_time_in;
      end
      pass_ff    <= pass_in;
      is_joy_ff  <= is_joy_in;
      boosted_ff <= boosted_in;
      auto_ff    <= auto_in;
   end

   always_comb begin
      lane_ctrl.load    = req_accept;
      lane_ctrl.mul     = (state_ff == jocm_pkg::ST_MUL);
      lane_ctrl.scale   = (state_ff == jocm_pkg::ST_BOOST);
      lane_ctrl.boosted = boosted_ff;
   end

   jocm_lane u_lane_lin (
      .clock    (clock),
      .ctrl     (lane_ctrl),
      .axes     (axes),
      .prim_idx (cfg.axis_map[3:0]),
      .sec_sel  (cfg.axis_map[11:8]),
      .gain     (cfg.linear_gain),
      .ratio    (cfg.linear_boost),
      .result   (lin_res)
   );

   jocm_lane u_lane_ang (
      .clock    (clock),
      .ctrl     (lane_ctrl),
      .axes     (axes),
      .prim_idx (cfg.axis_map[7:4]),
      .sec_sel  (cfg.axis_map[15:12]),
      .gain     (cfg.angular_gain),
      .ratio    (cfg.angular_boost),
      .result   (ang_res)
   );

   jocm_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (push),
      .is_joy     (is_joy_ff),
      .pass       (pass_ff),
      .lin        (lin_res),
      .ang        (ang_res),
      .auto_twist (auto_ff),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   assign rsp_has_twist     = rsp.has_twist;
   assign rsp_has_status    = rsp.has_status;
   assign rsp_pass_status   = rsp.pass_status;
   assign rsp_out_linear_x  = rsp.twist.lin_x;
   assign rsp_out_linear_y  = rsp.twist.lin_y;
   assign rsp_out_linear_z  = rsp.twist.lin_z;
   assign rsp_out_angular_x = rsp.twist.ang_x;
   assign rsp_out_angular_y = rsp.twist.ang_y;
   assign rsp_out_angular_z = rsp.twist.ang_z;

   // a finished word waits while the output register is stalled
   `JOCM_ASSERT(a_push_hold, clock, reset, (state_ff == jocm_pkg::ST_PUSH && rsp_valid && rsp_stall) |=> (state_ff == jocm_pkg::ST_PUSH))
   `JOCM_ASSERT(a_joy_start, clock, reset, (req_accept && !req_mode && deadman) |=> (state_ff == jocm_pkg::ST_MUL && override_ff))
   `JOCM_ASSERT(a_joy_fields, clock, reset, (rsp_valid && rsp_has_twist && !rsp_has_status) |-> (rsp_out_linear_y == 16'sd0 && rsp_out_angular_y == 16'sd0))
   `JOCM_ASSERT(a_pass_word, clock, reset, (rsp_valid && rsp_pass_status) |-> (rsp_has_status && rsp_has_twist))

endmodule

`default_nettype wire
